// ----- src/assert_macros.svh -----
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PRAR_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define PRAR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define PRAR_ASSERT(label, clk, rst_n, expr)
`define PRAR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/prar_pkg.sv -----
`default_nettype none
package prar_pkg;

    localparam int COORD_W    = 32;
    localparam int GUARD_BITS = 16;
    localparam int XY_W       = 52;
    localparam int Z_W        = 41;
    localparam int INV_W      = 32;
    localparam int ANG_FRAC   = 32;
    localparam logic [63:0] RAD_TO_DEG_Q32 = 64'd246083499208;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] angle_deg;
    } t_in_beat;

    typedef struct packed {
        logic signed [COORD_W-1:0] rotated_x;
        logic signed [COORD_W-1:0] rotated_y;
    } t_out_beat;

    typedef struct packed {
        logic signed [XY_W-1:0]    x;
        logic signed [XY_W-1:0]    y;
        logic signed [Z_W-1:0]     z;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } t_cord;

    // shift-subtract long division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = val;
        r = '0;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (b > n) begin
                b = b >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (b != 64'd0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // atan(2^-stage) in degrees, 32 fraction bits
    function automatic logic [63:0] stage_angle(input int stage);
        logic [63:0]  sum;
        logic [63:0]  term;
        logic [127:0] prod;
        logic [63:0]  res;
        int           e;
        sum = '0;
        if (stage == 0) begin
            res = 64'd45 << ANG_FRAC;
        end else begin
            for (int k = 0; k < 32; k++) begin
                e = stage * (2 * k + 1);
                if (e <= 62) begin
                    term = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
                    if (k[0]) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                end
            end
            prod = {64'd0, sum} * {64'd0, RAD_TO_DEG_Q32};
            res  = prod[125:62];
        end
        return res;
    endfunction

    // inverse cordic gain, 32 fraction bits
    function automatic logic [INV_W-1:0] inverse_gain(input int stages);
        logic [63:0] p;
        logic [63:0] quo;
        p = 64'd1 << 63;
        for (int i = 1; i < 32; i++) begin
            if (i < stages) begin
                p = p + (p >> (2 * i));
            end
        end
        quo = udiv64(64'd1 << 63, isqrt64(p));
        return quo[INV_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- src/prar_reduce.sv -----
`default_nettype none
module prar_reduce #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire prar_pkg::t_in_beat i_beat,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output prar_pkg::t_cord         o_cord
);
    import prar_pkg::*;

    localparam int K_W  = COORD_W - FRAC_BITS;
    localparam int U_W  = K_W + 1;
    localparam int RC_W = U_W - 8;
    localparam int PR_W = U_W + RC_W;
    localparam int W_W  = U_W + 2;
    localparam int M_W  = 9;
    localparam int R_W  = M_W + FRAC_BITS + 1;
    localparam int D_W  = COORD_W + 1;

    localparam int DEG_QUARTER = 90;
    localparam int DEG_HALF    = 180;
    localparam int DEG_3Q      = 270;
    localparam int DEG_FULL    = 360;

    localparam logic [U_W-1:0]  OFFSET =
        U_W'(DEG_FULL * ((2 ** (K_W - 1) + DEG_FULL - 1) / DEG_FULL));
    localparam logic [RC_W-1:0] RECIP = RC_W'((2 ** U_W) / DEG_FULL);
    localparam logic signed [R_W-1:0] HALF_Q = R_W'(DEG_HALF) << FRAC_BITS;
    localparam logic signed [R_W-1:0] FULL_Q = R_W'(DEG_FULL) << FRAC_BITS;

    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1: offsets and biased integer degrees
    logic                        r_v1;
    logic signed [D_W-1:0]       r_dx1, r_dy1;
    logic signed [COORD_W-1:0]   r_cx1, r_cy1;
    logic [U_W-1:0]              r_u1;
    logic [FRAC_BITS-1:0]        r_frac1;
    logic [U_W-1:0]              n_u1;

    // stage 2: reciprocal product
    logic                        r_v2;
    logic signed [D_W-1:0]       r_dx2, r_dy2;
    logic signed [COORD_W-1:0]   r_cx2, r_cy2;
    logic [U_W-1:0]              r_u2;
    logic [PR_W-1:0]             r_prod2;
    logic [FRAC_BITS-1:0]        r_frac2;

    // stage 3: degrees modulo 360
    logic                        r_v3;
    logic signed [D_W-1:0]       r_dx3, r_dy3;
    logic signed [COORD_W-1:0]   r_cx3, r_cy3;
    logic [M_W-1:0]              r_kmod3;
    logic [FRAC_BITS-1:0]        r_frac3;
    logic [RC_W-1:0]             q_est;
    logic [W_W-1:0]              rem_w;
    logic [9:0]                  rem;
    logic [M_W-1:0]              n_kmod3;

    // stage 4: half-turn fold, working formats
    logic                        r_v4;
    t_cord                       r_cord4;
    t_cord                       n_cord4;
    logic signed [R_W-1:0]       pos_q, sub_half, sub_full, rs;
    logic                        above_q, fold;
    logic signed [D_W:0]         dxn, dyn;

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v4;
    assign o_cord  = r_cord4;

    assign n_u1 = U_W'($signed(i_beat.angle_deg[COORD_W-1:FRAC_BITS])) + OFFSET;

    always_comb begin
        q_est   = r_prod2[PR_W-1:U_W];
        rem_w   = W_W'(r_u2) - W_W'(q_est) * W_W'(DEG_FULL);
        rem     = rem_w[9:0];
        n_kmod3 = (rem >= 10'(DEG_FULL)) ? M_W'(rem - 10'(DEG_FULL)) : M_W'(rem);
    end

    always_comb begin
        pos_q      = R_W'({r_kmod3, r_frac3});
        sub_half   = pos_q - HALF_Q;
        sub_full   = pos_q - FULL_Q;
        above_q    = (r_kmod3 > M_W'(DEG_QUARTER))
                  || ((r_kmod3 == M_W'(DEG_QUARTER)) && (r_frac3 != '0));
        fold       = above_q && (r_kmod3 < M_W'(DEG_3Q));
        if (fold) begin
            rs = sub_half;
        end else if (r_kmod3 >= M_W'(DEG_3Q)) begin
            rs = sub_full;
        end else begin
            rs = pos_q;
        end
        dxn        = fold ? -(D_W+1)'(r_dx3) : (D_W+1)'(r_dx3);
        dyn        = fold ? -(D_W+1)'(r_dy3) : (D_W+1)'(r_dy3);
        n_cord4.x  = XY_W'(dxn) <<< GUARD_BITS;
        n_cord4.y  = XY_W'(dyn) <<< GUARD_BITS;
        n_cord4.z  = Z_W'(rs) <<< (ANG_FRAC - FRAC_BITS);
        n_cord4.cx = r_cx3;
        n_cord4.cy = r_cy3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_dx1   <= D_W'(i_beat.point_x) - D_W'(i_beat.center_x);
            r_dy1   <= D_W'(i_beat.point_y) - D_W'(i_beat.center_y);
            r_cx1   <= i_beat.center_x;
            r_cy1   <= i_beat.center_y;
            r_u1    <= n_u1;
            r_frac1 <= i_beat.angle_deg[FRAC_BITS-1:0];
        end
        if (rdy2 && r_v1) begin
            r_dx2   <= r_dx1;
            r_dy2   <= r_dy1;
            r_cx2   <= r_cx1;
            r_cy2   <= r_cy1;
            r_u2    <= r_u1;
            r_prod2 <= PR_W'(r_u1) * PR_W'(RECIP);
            r_frac2 <= r_frac1;
        end
        if (rdy3 && r_v2) begin
            r_dx3   <= r_dx2;
            r_dy3   <= r_dy2;
            r_cx3   <= r_cx2;
            r_cy3   <= r_cy2;
            r_kmod3 <= n_kmod3;
            r_frac3 <= r_frac2;
        end
        if (rdy4 && r_v3) begin
            r_cord4 <= n_cord4;
        end
    end

endmodule
`default_nettype wire

// ----- src/prar_cell.sv -----
`default_nettype none
module prar_cell #(
    parameter int STAGE = 0
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire prar_pkg::t_cord i_cord,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output prar_pkg::t_cord      o_cord
);
    import prar_pkg::*;

    localparam logic signed [Z_W-1:0] ANGLE = Z_W'(stage_angle(STAGE));

    logic                   r_valid;
    t_cord                  r_cord;
    t_cord                  n_cord;
    logic signed [XY_W-1:0] xs, ys;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cord  = r_cord;

    always_comb begin
        xs     = i_cord.x >>> STAGE;
        ys     = i_cord.y >>> STAGE;
        n_cord = i_cord;
        if (!i_cord.z[Z_W-1]) begin
            n_cord.x = i_cord.x - ys;
            n_cord.y = i_cord.y + xs;
            n_cord.z = i_cord.z - ANGLE;
        end else begin
            n_cord.x = i_cord.x + ys;
            n_cord.y = i_cord.y - xs;
            n_cord.z = i_cord.z + ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cord <= n_cord;
        end
    end

endmodule
`default_nettype wire

// ----- src/prar_scale.sv -----
`default_nettype none
module prar_scale #(
    parameter int CORDIC_STAGES = 24
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire prar_pkg::t_cord i_cord,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output prar_pkg::t_out_beat  o_beat
);
    import prar_pkg::*;

    localparam logic [INV_W-1:0] INV_GAIN = inverse_gain(CORDIC_STAGES);
    localparam int HALF_W = XY_W / 2;
    localparam int HI_W   = XY_W - HALF_W;
    localparam int PP_W   = HI_W + INV_W;
    localparam int SUM_W  = XY_W + INV_W;
    localparam int SHIFT  = INV_W + GUARD_BITS;
    localparam int QM_W   = SUM_W - SHIFT;
    localparam int RES_W  = QM_W + 2;
    localparam logic [SUM_W-1:0] ROUND = SUM_W'(1) << (SHIFT - 1);
    localparam logic signed [RES_W-1:0] SAT_HI = (RES_W'(1) << (COORD_W - 1)) - RES_W'(1);
    localparam logic signed [RES_W-1:0] SAT_LO = -SAT_HI - RES_W'(1);

    logic rdy0, rdy1, rdy2, rdy3;

    // stage 0: sign and magnitude
    logic                      r_v0;
    logic                      r_neg_x0, r_neg_y0;
    logic [XY_W-1:0]           r_mag_x0, r_mag_y0;
    logic signed [COORD_W-1:0] r_cx0, r_cy0;

    // stage 1: partial products with the inverse gain
    logic                      r_v1;
    logic                      r_neg_x1, r_neg_y1;
    logic [PP_W-1:0]           r_ppl_x1, r_pph_x1, r_ppl_y1, r_pph_y1;
    logic signed [COORD_W-1:0] r_cx1, r_cy1;

    // stage 2: sum and round
    logic                      r_v2;
    logic                      r_neg_x2, r_neg_y2;
    logic [QM_W-1:0]           r_q_x2, r_q_y2;
    logic signed [COORD_W-1:0] r_cx2, r_cy2;
    logic [SUM_W-1:0]          sum_x, sum_y;

    // stage 3: origin add and saturate
    logic                      r_v3;
    t_out_beat                 r_beat3;
    t_out_beat                 n_beat3;
    logic signed [RES_W-1:0]   res_x, res_y;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign rdy0    = !r_v0 || rdy1;
    assign o_ready = rdy0;
    assign o_valid = r_v3;
    assign o_beat  = r_beat3;

    always_comb begin
        sum_x = (SUM_W'(r_pph_x1) << HALF_W) + SUM_W'(r_ppl_x1) + ROUND;
        sum_y = (SUM_W'(r_pph_y1) << HALF_W) + SUM_W'(r_ppl_y1) + ROUND;
    end

    always_comb begin
        res_x = r_neg_x2 ? RES_W'(r_cx2) - RES_W'(r_q_x2) : RES_W'(r_cx2) + RES_W'(r_q_x2);
        res_y = r_neg_y2 ? RES_W'(r_cy2) - RES_W'(r_q_y2) : RES_W'(r_cy2) + RES_W'(r_q_y2);
        if (res_x > SAT_HI) begin
            n_beat3.rotated_x = SAT_HI[COORD_W-1:0];
        end else if (res_x < SAT_LO) begin
            n_beat3.rotated_x = SAT_LO[COORD_W-1:0];
        end else begin
            n_beat3.rotated_x = res_x[COORD_W-1:0];
        end
        if (res_y > SAT_HI) begin
            n_beat3.rotated_y = SAT_HI[COORD_W-1:0];
        end else if (res_y < SAT_LO) begin
            n_beat3.rotated_y = SAT_LO[COORD_W-1:0];
        end else begin
            n_beat3.rotated_y = res_y[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy0) begin
                r_v0 <= i_valid;
            end
            if (rdy1) begin
                r_v1 <= r_v0;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0 && i_valid) begin
            r_neg_x0 <= i_cord.x[XY_W-1];
            r_neg_y0 <= i_cord.y[XY_W-1];
            r_mag_x0 <= i_cord.x[XY_W-1] ? XY_W'(-i_cord.x) : XY_W'(i_cord.x);
            r_mag_y0 <= i_cord.y[XY_W-1] ? XY_W'(-i_cord.y) : XY_W'(i_cord.y);
            r_cx0    <= i_cord.cx;
            r_cy0    <= i_cord.cy;
        end
        if (rdy1 && r_v0) begin
            r_neg_x1 <= r_neg_x0;
            r_neg_y1 <= r_neg_y0;
            r_ppl_x1 <= PP_W'(r_mag_x0[HALF_W-1:0]) * PP_W'(INV_GAIN);
            r_pph_x1 <= PP_W'(r_mag_x0[XY_W-1:HALF_W]) * PP_W'(INV_GAIN);
            r_ppl_y1 <= PP_W'(r_mag_y0[HALF_W-1:0]) * PP_W'(INV_GAIN);
            r_pph_y1 <= PP_W'(r_mag_y0[XY_W-1:HALF_W]) * PP_W'(INV_GAIN);
            r_cx1    <= r_cx0;
            r_cy1    <= r_cy0;
        end
        if (rdy2 && r_v1) begin
            r_neg_x2 <= r_neg_x1;
            r_neg_y2 <= r_neg_y1;
            r_q_x2   <= sum_x[SUM_W-1:SHIFT];
            r_q_y2   <= sum_y[SUM_W-1:SHIFT];
            r_cx2    <= r_cx1;
            r_cy2    <= r_cy1;
        end
        if (rdy3 && r_v2) begin
            r_beat3 <= n_beat3;
        end
    end

endmodule
`default_nettype wire

// ----- src/point_rotate_about_origin.sv -----
// Rotates a point about an origin by an angle in degrees (signed Q16.16 by
// default, FRAC_BITS fraction bits in general), using a pipelined CORDIC.
// Input channel: i_in_valid / o_in_ready carry one beat holding the point,
// the origin and the angle. Output channel: o_out_valid / i_out_ready carry
// one beat holding the rotated point, saturated to 32 bits.
// Each input beat gives exactly one output beat, in order.
// Path: angle reduction and folding, then the CORDIC cells, then gain
// scaling, rounding and origin add.
// Throughput: one beat per cycle; every stage is a register with its own
// valid bit, so a new beat enters each cycle the pipeline moves.
// Stall: when i_out_ready is low, the output beat holds and the stages behind
// it keep filling their empty slots; o_in_ready drops only when every stage
// holds a beat. Up to CORDIC_STAGES + 8 beats can be in flight.
// Reset: synchronous, active low on i_rst_n; clears all stage valid bits,
// so the pipeline comes up empty and ready.
`default_nettype none
`include "assert_macros.svh"
module point_rotate_about_origin #(
    parameter int CORDIC_STAGES = 24,
    parameter int FRAC_BITS     = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire prar_pkg::t_in_beat i_in_beat,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output prar_pkg::t_out_beat     o_out_beat
);
    import prar_pkg::*;

    localparam int FRONT_DEPTH = 4;
    localparam int BACK_DEPTH  = 4;
    localparam int DEPTH       = FRONT_DEPTH + CORDIC_STAGES + BACK_DEPTH;
    localparam int OCC_W       = $clog2(DEPTH + 1);

    logic [CORDIC_STAGES:0] chain_valid;
    logic [CORDIC_STAGES:0] chain_ready;
    t_cord                  chain_cord [CORDIC_STAGES+1];

    logic                   in_acc, out_acc;
    logic [OCC_W-1:0]       r_occ;
    logic [OCC_W-1:0]       n_occ;

    prar_reduce #(
        .FRAC_BITS (FRAC_BITS)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_beat  (i_in_beat),
        .o_valid (chain_valid[0]),
        .i_ready (chain_ready[0]),
        .o_cord  (chain_cord[0])
    );

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        prar_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .o_ready (chain_ready[g]),
            .i_cord  (chain_cord[g]),
            .o_valid (chain_valid[g+1]),
            .i_ready (chain_ready[g+1]),
            .o_cord  (chain_cord[g+1])
        );
    end

    prar_scale #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (chain_valid[CORDIC_STAGES]),
        .o_ready (chain_ready[CORDIC_STAGES]),
        .i_cord  (chain_cord[CORDIC_STAGES]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_beat  (o_out_beat)
    );

    // beats in flight
    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;
    assign n_occ   = r_occ + OCC_W'(in_acc) - OCC_W'(out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= n_occ;
        end
    end

    `PRAR_ASSERT(a_occ_bound, i_clk, i_rst_n, r_occ <= OCC_W'(DEPTH))
    `PRAR_ASSERT_IMPL(a_empty_no_out, i_clk, i_rst_n, r_occ == '0, !o_out_valid)
    `PRAR_ASSERT_IMPL(a_empty_ready, i_clk, i_rst_n, r_occ == '0, o_in_ready)
    `PRAR_ASSERT_IMPL(a_full_stall, i_clk, i_rst_n, (r_occ == OCC_W'(DEPTH)) && !i_out_ready, !o_in_ready)

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
    import prar_pkg::*;

    localparam int STAGES = 24;
    localparam int FRAC = 16;
    localparam int GUARD = 16;
    localparam logic [63:0] RAD_TO_DEG = 64'd246083499208;
    localparam longint FULL_TURN = 64'sd360 <<< FRAC;
    localparam longint HALF_TURN = 64'sd180 <<< FRAC;
    localparam longint QUARTER_TURN = 64'sd90 <<< FRAC;
    localparam logic signed [31:0] MAX_C = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN_C = 32'sh8000_0000;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    localparam int RANDOM_ITEMS = 1325;
    localparam int TAIL_ITEMS = 200;
    localparam int TAIL_CYCLES = 64;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        t_in_beat  beat;
        bit        typed;
        t_out_beat want;
    } t_dir_row;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_beat  in_beat = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_beat;

    bit        row_typed = 1'b0;
    t_out_beat row_want = '0;
    bit        no_idle = 1'b0;
    int        rx_hold = 0;
    int        stall_cycles = 0;
    int        fail_count = 0;

    longint          atan_tbl [STAGES];
    longint unsigned gain_inv;
    t_out_beat       pending_rotations [$];
    t_dir_row        dir_rows [$];

    point_rotate_about_origin #(
        .CORDIC_STAGES(STAGES),
        .FRAC_BITS    (FRAC)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_beat  (in_beat),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_beat (out_beat)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // atan(2^-stage) in degrees, 32 fraction bits
    function automatic longint unsigned atan_deg_q32(int stage);
        longint unsigned acc;
        longint unsigned piece;
        logic [127:0]    wide;
        int              e;
        acc = 0;
        if (stage == 0) begin
            return 64'd45 << 32;
        end
        for (int k = 0; k < 64; k++) begin
            e = stage * (2 * k + 1);
            if (e <= 62) begin
                piece = (64'd1 << (62 - e)) / 64'(2 * k + 1);
                if (k % 2 == 1) begin
                    acc = acc - piece;
                end else begin
                    acc = acc + piece;
                end
            end
        end
        wide = 128'(acc) * 128'(RAD_TO_DEG);
        return wide[125:62];
    endfunction

    function automatic longint unsigned gain_inverse_q32();
        longint unsigned prod_q62;
        longint unsigned root;
        longint unsigned trial;
        logic [127:0]    sq;
        prod_q62 = 64'd1 << 63;
        for (int i = 1; i < STAGES; i++) begin
            prod_q62 = prod_q62 + (prod_q62 >> (2 * i));
        end
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            sq = 128'(trial) * 128'(trial);
            if (sq <= 128'(prod_q62)) begin
                root = trial;
            end
        end
        return (64'd1 << 63) / root;
    endfunction

    function automatic longint round_scaled(longint v);
        bit              neg;
        longint unsigned mag;
        logic [127:0]    p;
        longint unsigned q;
        neg = v < 0;
        mag = neg ? -v : v;
        p = 128'(mag) * 128'(gain_inv);
        p = p + (128'd1 << (32 + GUARD - 1));
        q = p[111:48];
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return MAX_C;
        end
        if (v < -64'sd2147483648) begin
            return MIN_C;
        end
        return 32'(v);
    endfunction

    function automatic t_out_beat predict_rotation(t_in_beat b);
        longint    cx;
        longint    cy;
        longint    dx;
        longint    dy;
        longint    ang;
        longint    x;
        longint    y;
        longint    z;
        longint    xs;
        longint    ys;
        t_out_beat res;
        cx = longint'(b.center_x);
        cy = longint'(b.center_y);
        dx = longint'(b.point_x) - cx;
        dy = longint'(b.point_y) - cy;
        ang = longint'(b.angle_deg) % FULL_TURN;
        if (ang < 0) begin
            ang = ang + FULL_TURN;
        end
        if (ang >= HALF_TURN) begin
            ang = ang - FULL_TURN;
        end
        // fold into the right half plane
        if (ang > QUARTER_TURN || ang < -QUARTER_TURN) begin
            ang = (ang > 0) ? ang - HALF_TURN : ang + HALF_TURN;
            dx = -dx;
            dy = -dy;
        end
        z = ang <<< (32 - FRAC);
        x = dx <<< GUARD;
        y = dy <<< GUARD;
        for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - atan_tbl[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + atan_tbl[i];
            end
        end
        res.rotated_x = clamp32(cx + round_scaled(x));
        res.rotated_y = clamp32(cy + round_scaled(y));
        return res;
    endfunction

    function automatic logic signed [31:0] deg_q16(int d);
        return d * 65536;
    endfunction

    function automatic t_dir_row row(logic signed [31:0] px, logic signed [31:0] py,
                                     logic signed [31:0] cx, logic signed [31:0] cy,
                                     logic signed [31:0] ang, bit typed,
                                     logic signed [31:0] wx, logic signed [31:0] wy);
        t_dir_row r;
        r.beat.point_x = px;
        r.beat.point_y = py;
        r.beat.center_x = cx;
        r.beat.center_y = cy;
        r.beat.angle_deg = ang;
        r.typed = typed;
        r.want.rotated_x = wx;
        r.want.rotated_y = wy;
        return r;
    endfunction

    function automatic logic signed [31:0] small_coord();
        return int'($urandom_range(0, 1 << 25)) - (1 << 24);
    endfunction

    function automatic logic signed [31:0] scaled_coord();
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, 31);
    endfunction

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return MIN_C;
            1: return MAX_C;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_beat random_rotation();
        t_in_beat b;
        b.point_x = $urandom;
        b.point_y = $urandom;
        b.center_x = $urandom;
        b.center_y = $urandom;
        b.angle_deg = $urandom;
        case ($urandom_range(0, 9))
            0, 1: begin
            end
            2, 3, 4: begin
                b.point_x = small_coord();
                b.point_y = small_coord();
                b.center_x = small_coord();
                b.center_y = small_coord();
                b.angle_deg = int'($urandom_range(0, 2 * 1080 * 65536)) - 1080 * 65536;
            end
            5: begin
                // near quarter-turn boundaries
                b.point_x = small_coord();
                b.point_y = small_coord();
                b.center_x = small_coord();
                b.center_y = small_coord();
                b.angle_deg = deg_q16(int'($urandom_range(0, 16)) * 90 - 720)
                              + int'($urandom_range(0, 6)) - 3;
            end
            6: begin
                b.point_x = b.center_x;
                b.point_y = b.center_y;
            end
            7: begin
                b.point_x = pick_extreme();
                b.point_y = pick_extreme();
                b.center_x = pick_extreme();
                b.center_y = pick_extreme();
                b.angle_deg = pick_extreme();
            end
            default: begin
                b.point_x = scaled_coord();
                b.point_y = scaled_coord();
                b.center_x = scaled_coord();
                b.center_y = scaled_coord();
            end
        endcase
        return b;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        fail_count++;
        $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
    endtask

    task automatic send_beat(t_in_beat b, bit typed, t_out_beat want);
        int gap;
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat <= b;
        row_typed <= typed;
        row_want <= want;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // scoreboard
    always @(posedge clk) begin
        t_out_beat want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (pending_rotations.size() == 0) begin
                    report_mismatch("result beat with nothing pending",
                                    out_beat.rotated_x, '0);
                end else begin
                    want = pending_rotations.pop_front();
                    if (out_beat.rotated_x !== want.rotated_x) begin
                        report_mismatch("rotated_x", out_beat.rotated_x, want.rotated_x);
                    end
                    if (out_beat.rotated_y !== want.rotated_y) begin
                        report_mismatch("rotated_y", out_beat.rotated_y, want.rotated_y);
                    end
                end
            end
            if (in_valid && in_ready) begin
                if (row_typed) begin
                    pending_rotations.push_back(row_want);
                end else begin
                    pending_rotations.push_back(predict_rotation(in_beat));
                end
            end
        end
    end

    always @(posedge clk) begin
        if (no_idle) begin
            out_ready <= 1'b1;
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            rx_hold <= $urandom_range(0, 6);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < STAGES; i++) begin
            atan_tbl[i] = atan_deg_q32(i);
        end
        gain_inv = gain_inverse_q32();

        // zero offset and saturation rows are known outright
        dir_rows.push_back(row(0, 0, 0, 0, 0, 1, 0, 0));
        dir_rows.push_back(row(32'sh1234_5678, -32'sh0ABC_DEF0, 32'sh1234_5678,
                               -32'sh0ABC_DEF0, deg_q16(37) + 32'sh8000, 1,
                               32'sh1234_5678, -32'sh0ABC_DEF0));
        dir_rows.push_back(row(MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, 1, MAX_C, MAX_C));
        dir_rows.push_back(row(MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, 1, MIN_C, MIN_C));
        dir_rows.push_back(row(MIN_C, MIN_C, MAX_C, MAX_C, deg_q16(180), 1, MAX_C, MAX_C));
        dir_rows.push_back(row(MAX_C, MAX_C, MIN_C, MIN_C, deg_q16(180), 1, MIN_C, MIN_C));
        dir_rows.push_back(row(MIN_C, MIN_C, MAX_C, MAX_C, deg_q16(-180), 1, MAX_C, MAX_C));
        dir_rows.push_back(row(MAX_C, MAX_C, MIN_C, MIN_C, deg_q16(540), 1, MIN_C, MIN_C));
        dir_rows.push_back(row(ONE, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(row(ONE, 0, 0, 0, deg_q16(90), 0, 0, 0));
        dir_rows.push_back(row(ONE, ONE, 0, 0, deg_q16(90) + 1, 0, 0, 0));
        dir_rows.push_back(row(ONE, ONE, 0, 0, deg_q16(-90), 0, 0, 0));
        dir_rows.push_back(row(ONE, ONE, 0, 0, deg_q16(-90) - 1, 0, 0, 0));
        dir_rows.push_back(row(3 * ONE, -2 * ONE, ONE, ONE, deg_q16(180) - 1, 0, 0, 0));
        dir_rows.push_back(row(3 * ONE, -2 * ONE, ONE, ONE, deg_q16(360), 0, 0, 0));
        dir_rows.push_back(row(3 * ONE, -2 * ONE, ONE, ONE, deg_q16(-360), 0, 0, 0));
        dir_rows.push_back(row(3 * ONE, -2 * ONE, ONE, ONE, deg_q16(765), 0, 0, 0));
        dir_rows.push_back(row(5 * ONE, 7 * ONE, -ONE, 2 * ONE, MAX_C, 0, 0, 0));
        dir_rows.push_back(row(5 * ONE, 7 * ONE, -ONE, 2 * ONE, MIN_C, 0, 0, 0));
        dir_rows.push_back(row(1, 0, 0, 0, deg_q16(45), 0, 0, 0));
        dir_rows.push_back(row(1, 1, 0, 0, deg_q16(30), 0, 0, 0));
        dir_rows.push_back(row(-ONE, -ONE, 0, 0, -1, 0, 0, 0));
        dir_rows.push_back(row(MAX_C, MAX_C, MIN_C, MIN_C, deg_q16(90), 0, 0, 0));
        dir_rows.push_back(row(MIN_C, 0, MAX_C, 0, deg_q16(-90), 0, 0, 0));
        dir_rows.push_back(row(32'sh0000_8000, -1, 0, 0, deg_q16(60), 0, 0, 0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r]) begin
            send_beat(dir_rows[r].beat, dir_rows[r].typed, dir_rows[r].want);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            no_idle <= (n >= RANDOM_ITEMS - TAIL_ITEMS) || ((n / 100) % 4 == 3);
            // let the pipeline drain once mid-run
            if (n == RANDOM_ITEMS / 2) begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_rotations.size() != 0) @(posedge clk);
            end
            send_beat(random_rotation(), 1'b0, '0);
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_rotations.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end
endmodule

// ----- point_rotate_about_origin.f -----
+incdir+src
src/prar_pkg.sv
src/prar_reduce.sv
src/prar_cell.sv
src/prar_scale.sv
src/point_rotate_about_origin.sv
test/testbench.sv
